// ===== hw/rtl/deque_with_remove_by_value_unit_macros.svh =====
// Assertion macros for the deque unit
`ifndef DEQUE_WITH_REMOVE_BY_VALUE_UNIT_MACROS_SVH
`define DEQUE_WITH_REMOVE_BY_VALUE_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define DQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define DQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hw/rtl/dqrm_pkg.sv =====
`default_nettype none
package dqrm_pkg;
	localparam int Depth = 16;
	localparam int ValueBits = 32;
	localparam int IdxBits = $clog2(Depth);
	localparam int CntBits = $clog2(Depth + 1);

	localparam logic [2:0] CMD_PUSH = 3'd0;
	localparam logic [2:0] CMD_POP = 3'd1;
	localparam logic [2:0] CMD_TAKE = 3'd2;
	localparam logic [2:0] CMD_PEEKH = 3'd3;
	localparam logic [2:0] CMD_PEEKT = 3'd4;
	localparam logic [2:0] CMD_REMOVE = 3'd5;
	localparam logic [2:0] CMD_CLEAR = 3'd6;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_MISS = 3'd3;
	localparam logic [2:0] ST_ZERO = 3'd4;

	typedef logic [ValueBits-1:0] value_t;
	typedef logic [IdxBits-1:0] idx_t;
	typedef logic [CntBits-1:0] cnt_t;

	// memory port control from sequencer
	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		value_t wr_data;
	} mem_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dqrm_if.sv =====
`default_nettype none
interface dqrm_cmd_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	dqrm_pkg::value_t value;
	modport source(output valid, command, value, input ready);
	modport sink(input valid, command, value, output ready);
endinterface

interface dqrm_res_if;
	logic valid;
	logic ready;
	dqrm_pkg::value_t value_out;
	logic [2:0] status;
	dqrm_pkg::cnt_t length;
	modport source(output valid, value_out, status, length, input ready);
	modport sink(input valid, value_out, status, length, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dqrm_ram.sv =====
`default_nettype none
module dqrm_ram #(
	parameter int Words = 16,
	parameter int Bits = 32
) (
	input wire logic clk,
	input wire logic rd_en,
	input wire logic [$clog2(Words)-1:0] rd_addr,
	output logic [Bits-1:0] rd_data,
	input wire logic wr_en,
	input wire logic [$clog2(Words)-1:0] wr_addr,
	input wire logic [Bits-1:0] wr_data
);
	logic [Bits-1:0] mem [Words];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/dqrm_seq.sv =====
`default_nettype none
`include "deque_with_remove_by_value_unit_macros.svh"
module dqrm_seq (
	input wire logic clk,
	input wire logic arst_n,
	dqrm_cmd_if.sink cmd,
	dqrm_res_if.source res,
	output dqrm_pkg::mem_ctl_t mc,
	input wire dqrm_pkg::value_t rd_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] cmd_q;
	dqrm_pkg::value_t val_q;
	dqrm_pkg::idx_t head_q;   // circular head pointer
	dqrm_pkg::cnt_t count_q;
	dqrm_pkg::cnt_t pos_q;    // logical position under work
	logic rvalid_q;
	dqrm_pkg::value_t rval_q;
	logic [2:0] rst_q;
	dqrm_pkg::cnt_t rlen_q;

	logic out_free;
	assign out_free = !rvalid_q || res.ready;
	assign cmd.ready = (state_q == S_IDLE) && out_free;
	assign res.valid = rvalid_q;
	assign res.value_out = rval_q;
	assign res.status = rst_q;
	assign res.length = rlen_q;

	// physical address of logical position
	function automatic dqrm_pkg::idx_t phys(dqrm_pkg::idx_t h, dqrm_pkg::cnt_t p);
		logic [dqrm_pkg::CntBits:0] s;
		s = {1'b0, dqrm_pkg::CntBits'(h)} + {1'b0, p};
		if (s >= (dqrm_pkg::CntBits+1)'(dqrm_pkg::Depth))
			s = s - (dqrm_pkg::CntBits+1)'(dqrm_pkg::Depth);
		return s[dqrm_pkg::IdxBits-1:0];
	endfunction

	logic acc;
	assign acc = cmd.valid && cmd.ready;
	logic [dqrm_pkg::CntBits:0] pos_next;
	assign pos_next = {1'b0, pos_q} + 1'b1;

	// memory port drive
	always_comb begin
		mc = '0;
		case (state_q)
			S_IDLE: begin
				mc.rd_en = acc;
				if (cmd.command == dqrm_pkg::CMD_POP || cmd.command == dqrm_pkg::CMD_PEEKT)
					mc.rd_addr = phys(head_q, count_q - 1'b1);
				else
					mc.rd_addr = head_q;
				mc.wr_en = acc && cmd.command == dqrm_pkg::CMD_PUSH &&
					cmd.value != '0 && count_q != dqrm_pkg::CntBits'(dqrm_pkg::Depth);
				mc.wr_addr = phys(head_q, count_q);
				mc.wr_data = cmd.value;
			end
			S_SCAN: begin
				mc.rd_en = 1'b1;
				mc.rd_addr = phys(head_q, pos_next[dqrm_pkg::CntBits-1:0]);
			end
			S_SHIFT: begin
				// rd_data holds entry pos+1; write it into pos, fetch pos+2
				mc.rd_en = 1'b1;
				mc.rd_addr = phys(head_q, pos_q + 2'd2);
				mc.wr_en = pos_next < {1'b0, count_q};
				mc.wr_addr = phys(head_q, pos_q);
				mc.wr_data = rd_data;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			rvalid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			// result beat: load from done, drop once taken
			if (state_q == S_DONE && out_free) rvalid_q <= 1'b1;
			else if (res.ready) rvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (acc) begin
					cmd_q <= cmd.command;
					val_q <= cmd.value;
					pos_q <= '0;
					rval_q <= '0;
					rst_q <= dqrm_pkg::ST_OK;
					state_q <= S_DONE;
					case (cmd.command)
						dqrm_pkg::CMD_PUSH:
							if (cmd.value == '0) rst_q <= dqrm_pkg::ST_ZERO;
							else if (count_q == dqrm_pkg::CntBits'(dqrm_pkg::Depth))
								rst_q <= dqrm_pkg::ST_FULL;
							else count_q <= count_q + 1'b1;
						dqrm_pkg::CMD_POP, dqrm_pkg::CMD_TAKE,
						dqrm_pkg::CMD_PEEKH, dqrm_pkg::CMD_PEEKT:
							if (count_q == '0) rst_q <= dqrm_pkg::ST_EMPTY;
							else state_q <= S_READ;
						dqrm_pkg::CMD_REMOVE:
							if (count_q == '0) rst_q <= dqrm_pkg::ST_MISS;
							else state_q <= S_SCAN;
						dqrm_pkg::CMD_CLEAR: count_q <= '0;
						default: ;
					endcase
				end
				S_READ: begin
					rval_q <= rd_data;
					if (cmd_q == dqrm_pkg::CMD_POP) count_q <= count_q - 1'b1;
					if (cmd_q == dqrm_pkg::CMD_TAKE) begin
						count_q <= count_q - 1'b1;
						head_q <= phys(head_q, dqrm_pkg::CntBits'(1));
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// rd_data is entry pos_q
					if (rd_data == val_q) begin
						rval_q <= rd_data;
						state_q <= S_SHIFT;
					end else if (pos_next >= {1'b0, count_q}) begin
						rst_q <= dqrm_pkg::ST_MISS;
						state_q <= S_DONE;
					end else pos_q <= pos_next[dqrm_pkg::CntBits-1:0];
				end
				S_SHIFT: begin
					if (pos_next >= {1'b0, count_q}) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end else pos_q <= pos_next[dqrm_pkg::CntBits-1:0];
				end
				S_DONE: if (out_free) begin
					rlen_q <= count_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DQ_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, count_q <= dqrm_pkg::CntBits'(dqrm_pkg::Depth))
	`DQ_ASSERT_NXT(a_acc_busy, clk, arst_n, acc, state_q != S_IDLE)
	`DQ_ASSERT_IMP(a_wr_shift, clk, arst_n, mc.wr_en && state_q != S_IDLE, state_q == S_SHIFT)
	`DQ_ASSERT_NXT(a_done_beat, clk, arst_n, state_q == S_DONE && out_free, rvalid_q)
endmodule
`default_nettype wire

// ===== hw/rtl/deque_with_remove_by_value_unit.sv =====
// channel | dir | payload
// cmd     | in  | command[3], value[32]
// res     | out | value_out[32], status[3], length[5]
// One command at a time through a single-port-read RAM sequencer.
// Push, clear and rejected commands go from idle straight to done; pop/take/peek
// pass through a read state; remove scans from the head to a match, then shifts
// each later entry down one place; a remove miss scans every entry held.
// Reset clears count and head; entries need no clearing. A stalled result
// holds the sequencer before the result register.
`default_nettype none
module deque_with_remove_by_value_unit (
	input wire logic clk,
	input wire logic arst_n,
	dqrm_cmd_if.sink cmd,
	dqrm_res_if.source res
);
	dqrm_pkg::mem_ctl_t mc;
	dqrm_pkg::value_t rd_data;

	dqrm_seq u_seq (.clk, .arst_n, .cmd, .res, .mc, .rd_data);

	dqrm_ram #(.Words(dqrm_pkg::Depth), .Bits(dqrm_pkg::ValueBits)) u_ram (
		.clk, .rd_en(mc.rd_en), .rd_addr(mc.rd_addr), .rd_data,
		.wr_en(mc.wr_en), .wr_addr(mc.wr_addr), .wr_data(mc.wr_data)
	);
endmodule
`default_nettype wire
